FILE: hdl/sample_bar_graph_glyph_builder_core_assert.svh
// Assertion macros for the bar graph glyph builder checker.
`ifndef SAMPLE_BAR_GRAPH_GLYPH_BUILDER_CORE_ASSERT_SVH
`define SAMPLE_BAR_GRAPH_GLYPH_BUILDER_CORE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define SBGG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SBGG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sbgg_pkg.sv
// Shared types, constants and functions of the bar graph glyph builder.
`default_nettype none

package sbgg_pkg;

    localparam int RING_LEN   = 20;
    localparam int SAMPLE_W   = 10;
    localparam int HEIGHT_W   = 4;
    localparam int GLYPH_W    = 5;
    localparam int ROW_CNT_W  = 6;
    localparam int ID_W       = 3;
    localparam int ROW_W      = 3;

    typedef struct packed {
        logic push;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;
        logic row_last;
    } t_dp_status;

    // Glyph number of a tile: top row 0,1,2,6; bottom row 3,4,5,7
    function automatic logic [ID_W-1:0] tile_glyph_id(input logic [1:0] tx, input logic ty);
        logic [ID_W-1:0] id;
        case (tx)
            2'd0:    id = 3'd0;
            2'd1:    id = 3'd1;
            2'd2:    id = 3'd2;
            default: id = 3'd6;
        endcase
        if (ty) begin
            id = (tx == 2'd3) ? 3'd7 : id + 3'd3;
        end
        return id;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/sample_bar_graph_glyph_builder_core.sv
// Top level of the sample bar graph glyph builder.
// Each accepted sample request joins a 20-deep history (oldest dropped) and the block
// then emits the whole 20x16 graph as 64 glyph rows, one per cycle while the master side
// takes them: glyphs in the order 0,3,1,4,2,5,6,7, rows 0..7 each, tlast on the final row.
// A sample request is taken only in the idle state; the 64-step row counter then steps through
// the rows, holding while the master side stalls. The input stays not ready until the last
// row has been loaded into the output register. After reset the history reads as all zero.
`default_nettype none

module sample_bar_graph_glyph_builder_core
    import sbgg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [9:0] sample
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [2:0] glyph_id, [5:3] glyph_row, [10:6] row_bits
    output logic             o_m_tlast
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    logic [ID_W-1:0]    w_glyph_id;
    logic [ROW_W-1:0]   w_glyph_row;
    logic [GLYPH_W-1:0] w_row_bits;

    sbgg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sbgg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_sample    (i_s_tdata[SAMPLE_W-1:0]),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_glyph_id  (w_glyph_id),
        .o_glyph_row (w_glyph_row),
        .o_row_bits  (w_row_bits),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = {5'b00000, w_row_bits, w_glyph_row, w_glyph_id};

endmodule

`default_nettype wire

FILE: hdl/sbgg_ctrl.sv
// Controller: takes one sample request, then sequences the 64-row burst.
`default_nettype none

module sbgg_ctrl
    import sbgg_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic r_state;
    logic n_state;

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_cmd.push = i_s_tvalid && (r_state == ST_IDLE);
    assign o_cmd.emit = (r_state == ST_BUSY) && i_status.slot_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.push) n_state = ST_BUSY;
            end
            ST_BUSY: begin
                if (o_cmd.emit && i_status.row_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sbgg_dp.sv
// Datapath: height history shift line, row counter, pixel logic and output register.
`default_nettype none

module sbgg_dp
    import sbgg_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_status               o_status,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic                i_m_tready,
    output logic                     o_m_tvalid,
    output logic [ID_W-1:0]          o_glyph_id,
    output logic [ROW_W-1:0]         o_glyph_row,
    output logic [GLYPH_W-1:0]       o_row_bits,
    output logic                     o_last
);

    // Oldest height at index 0, newest at the far end
    logic [HEIGHT_W-1:0]  r_hist [RING_LEN];
    logic [ROW_CNT_W-1:0] r_cnt;
    logic                 r_m_tvalid;
    logic [ID_W-1:0]      r_glyph_id;
    logic [ROW_W-1:0]     r_glyph_row;
    logic [GLYPH_W-1:0]   r_row_bits;
    logic                 r_last;

    // height = floor(sample * 15 / 1023), using 1023 = 1024 - 1
    logic [13:0]         w_prod;
    logic [HEIGHT_W-1:0] w_quo;
    logic [10:0]         w_rem;
    logic [HEIGHT_W-1:0] w_new_h;

    assign w_prod  = {i_sample, 4'b0000} - {4'b0000, i_sample};
    assign w_quo   = w_prod[13:10];
    assign w_rem   = {1'b0, w_prod[9:0]} + {7'b0000000, w_quo};
    assign w_new_h = (w_rem >= 11'd1023) ? w_quo + 4'd1 : w_quo;

    logic [1:0]          w_tx;
    logic                w_ty;
    logic [3:0]          w_y;
    logic [GLYPH_W-1:0]  w_bits;

    assign w_tx = r_cnt[5:4];
    assign w_ty = r_cnt[3];
    assign w_y  = {w_ty, r_cnt[2:0]};

    always_comb begin
        logic [4:0]          x;
        logic [HEIGHT_W-1:0] h;
        for (int c = 0; c < GLYPH_W; c++) begin
            x = 5'({3'b000, w_tx} * 5'd5) + 5'(c);
            h = r_hist[x];
            w_bits[GLYPH_W-1-c] = (x == 5'd0) || (w_y == 4'd15) || (w_y >= 4'd15 - h);
        end
    end

    assign o_status.slot_free = !r_m_tvalid || i_m_tready;
    assign o_status.row_last  = (r_cnt == '1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RING_LEN; i++) r_hist[i] <= '0;
        end else if (i_cmd.push) begin
            for (int i = 0; i < RING_LEN - 1; i++) r_hist[i] <= r_hist[i+1];
            r_hist[RING_LEN-1] <= w_new_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_m_tvalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_cnt      <= r_cnt + 1'b1;
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_glyph_id  <= tile_glyph_id(w_tx, w_ty);
            r_glyph_row <= r_cnt[2:0];
            r_row_bits  <= w_bits;
            r_last      <= o_status.row_last;
        end
    end

    assign o_m_tvalid  = r_m_tvalid;
    assign o_glyph_id  = r_glyph_id;
    assign o_glyph_row = r_glyph_row;
    assign o_row_bits  = r_row_bits;
    assign o_last      = r_last;

endmodule

`default_nettype wire

FILE: hdl/sbgg_checker.sv
// Port-level checker for the bar graph glyph builder, bound to the top level.
`default_nettype none

`include "sample_bar_graph_glyph_builder_core_assert.svh"

module sbgg_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic [15:0] i_s_tdata,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [15:0] o_m_tdata,
    input wire logic        o_m_tlast
);

    `SBGG_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "stalled row changed")

    `SBGG_ASSERT_NEXT(a_one_request, i_s_tvalid && o_s_tready, !o_s_tready, "second request taken during burst")

    `SBGG_ASSERT_SAME(a_last_row, o_m_tvalid && o_m_tlast, o_m_tdata[2:0] == 3'd7 && o_m_tdata[5:3] == 3'd7, "tlast not on final row of glyph 7")

    `SBGG_ASSERT_SAME(a_busy_no_ready, o_m_tvalid && !o_m_tlast, !o_s_tready, "input ready mid-burst")

    `SBGG_ASSERT_NEXT(a_row_step, o_m_tvalid && i_m_tready && !o_m_tlast && o_m_tdata[5:3] != 3'd7, o_m_tvalid && o_m_tdata[5:3] == $past(o_m_tdata[5:3]) + 3'd1, "glyph row did not advance")

endmodule

bind sample_bar_graph_glyph_builder_core sbgg_checker u_checker (.*);

`default_nettype wire

FILE: dv/sample_bar_graph_glyph_builder_core_tb.sv
// Self-checking testbench for the sample bar graph glyph builder core.
`timescale 1ns / 100ps

module sample_bar_graph_glyph_builder_core_tb;
    import sbgg_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 5;
    localparam int ROWS_PER_BAR  = 64;
    localparam int PLOT_ROWS     = 16;
    localparam int FULL_SCALE    = 1023;
    localparam int GLYPH_ROWS    = 8;
    localparam int TILES_ACROSS  = 4;
    localparam int TILES_DOWN    = 2;
    localparam int PHASE_ITEMS   = 130;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 80;

    localparam logic [3:0][ID_W-1:0] TOP_IDS    = {3'd6, 3'd2, 3'd1, 3'd0};
    localparam logic [3:0][ID_W-1:0] BOTTOM_IDS = {3'd7, 3'd5, 3'd4, 3'd3};

    typedef struct packed {
        logic [ID_W-1:0]    glyph_id;
        logic [ROW_W-1:0]   glyph_row;
        logic [GLYPH_W-1:0] row_bits;
        logic               last;
    } t_glyph_row;

    class graph_scoreboard;
        logic [SAMPLE_W-1:0] history [RING_LEN];
        int unsigned         wr_ptr;
        t_glyph_row          rows_due [$];
        int                  errors;

        function new();
            foreach (history[i]) history[i] = '0;
            wr_ptr = 0;
            errors = 0;
        endfunction

        function void note_sample(input logic [SAMPLE_W-1:0] value);
            int         heights [RING_LEN];
            int         px;
            int         py;
            int         n;
            t_glyph_row item;
            history[wr_ptr] = value;
            wr_ptr = (wr_ptr + 1) % RING_LEN;
            for (int x = 0; x < RING_LEN; x++) begin
                heights[x] = (int'(history[(wr_ptr + x) % RING_LEN]) * (PLOT_ROWS - 1))
                             / FULL_SCALE;
            end
            n = 0;
            for (int tx = 0; tx < TILES_ACROSS; tx++) begin
                for (int ty = 0; ty < TILES_DOWN; ty++) begin
                    for (int r = 0; r < GLYPH_ROWS; r++) begin
                        item.glyph_id  = (ty == 0) ? TOP_IDS[tx] : BOTTOM_IDS[tx];
                        item.glyph_row = ROW_W'(r);
                        item.row_bits  = '0;
                        for (int c = 0; c < GLYPH_W; c++) begin
                            px = tx * GLYPH_W + c;
                            py = ty * GLYPH_ROWS + r;
                            if (px == 0 || py == PLOT_ROWS - 1 ||
                                py >= (PLOT_ROWS - 1) - heights[px]) begin
                                item.row_bits[GLYPH_W-1-c] = 1'b1;
                            end
                        end
                        item.last = (n == ROWS_PER_BAR - 1);
                        rows_due.push_back(item);
                        n++;
                    end
                end
            end
        endfunction

        function void check_row(input t_glyph_row got);
            t_glyph_row want;
            if (rows_due.size() == 0) begin
                $display("%0t: unexpected glyph row id=%0d row=%0d bits=%b last=%b",
                         $time, got.glyph_id, got.glyph_row, got.row_bits, got.last);
                errors++;
                return;
            end
            want = rows_due.pop_front();
            if (got.glyph_id !== want.glyph_id) begin
                $display("%0t: glyph_id expected %0d actual %0d",
                         $time, want.glyph_id, got.glyph_id);
                errors++;
            end
            if (got.glyph_row !== want.glyph_row) begin
                $display("%0t: glyph_row expected %0d actual %0d",
                         $time, want.glyph_row, got.glyph_row);
                errors++;
            end
            if (got.row_bits !== want.row_bits) begin
                $display("%0t: row_bits expected %b actual %b",
                         $time, want.row_bits, got.row_bits);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;   // [9:0] sample
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // [2:0] glyph_id, [5:3] glyph_row, [10:6] row_bits
    logic        o_m_tlast;

    graph_scoreboard board = new();
    int              src_idle_pct;
    int              sink_idle_pct;
    bit              hold_off_req;
    int              stall_cycles;

    sample_bar_graph_glyph_builder_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Accepted requests and results, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                board.note_sample(i_s_tdata[SAMPLE_W-1:0]);
            end
            if (o_m_tvalid && i_m_tready) begin
                board.check_row('{glyph_id:  o_m_tdata[2:0],
                                  glyph_row: o_m_tdata[5:3],
                                  row_bits:  o_m_tdata[10:6],
                                  last:      o_m_tlast});
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    task automatic push_sample(input logic [SAMPLE_W-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'd0, value};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic push_random(input int count);
        logic [SAMPLE_W-1:0] value;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 2) begin
                case ($urandom_range(0, 3))
                    0:       value = 10'd0;
                    1:       value = 10'd1023;
                    2:       value = 10'd68;
                    default: value = 10'd69;
                endcase
            end else begin
                value = SAMPLE_W'($urandom_range(0, FULL_SCALE));
            end
            push_sample(value);
        end
    endtask

    initial begin
        logic [SAMPLE_W-1:0] directed [12];
        directed      = '{10'd0, 10'd1023, 10'd1, 10'd1022, 10'd68, 10'd69,
                          10'd681, 10'd682, 10'h155, 10'h2AA, 10'd511, 10'd512};
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_m_tready    = 1'b0;
        hold_off_req  = 1'b0;
        stall_cycles  = 0;
        src_idle_pct  = 17;
        sink_idle_pct = 58;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) push_sample(directed[i]);
        // full-scale run long enough to wrap the ring
        repeat (12) push_sample(10'd1023);

        push_random(PHASE_ITEMS / 4);
        hold_off_req = 1'b1;
        push_random(PHASE_ITEMS - PHASE_ITEMS / 4);

        src_idle_pct  = 58;
        sink_idle_pct = 17;
        push_random(PHASE_ITEMS);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        push_random(PHASE_ITEMS);

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (board.rows_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (board.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
